[hdl/u2dts_pkg.sv]
// ----------------------------------------------------------------------------
// u2dts_pkg
// Constants and the month table shared by the UNIX to DOS timestamp converter.
// ----------------------------------------------------------------------------
package u2dts_pkg;

	// 1 Jan 1980 00:00:00 in UNIX seconds; also 3652 whole days of 86400 s.
	localparam logic [28:0] EPOCH_SECS = 29'd315532800;

	// The day split divides by 86400 = 128 * 675.
	localparam logic [9:0]  DAY_DIV    = 10'd675;
	// floor(2^33 / 675); the quotient it gives is low by at most one.
	localparam logic [23:0] DAY_RECIP  = 24'd12725829;

	// ceil(2^19 / 15), exact for 15-bit dividends (divides by 60 after >> 2).
	localparam logic [15:0] MIN_RECIP  = 16'd34953;
	// ceil(2^13 / 15), exact for 9-bit dividends.
	localparam logic [9:0]  HOUR_RECIP = 10'd547;
	// ceil(2^24 / 365), exact for 15-bit dividends.
	localparam logic [15:0] YEAR_RECIP = 16'd45965;

	localparam logic [8:0]  DAYS_YEAR  = 9'd365;
	localparam logic [8:0]  FEB29_DOY  = 9'd59;

	// Day of year at which each month of a common year starts.
	function automatic logic [8:0] month_start(input logic [3:0] idx);
		logic [8:0] res;
		case (idx)
			4'd0:    res = 9'd0;
			4'd1:    res = 9'd31;
			4'd2:    res = 9'd59;
			4'd3:    res = 9'd90;
			4'd4:    res = 9'd120;
			4'd5:    res = 9'd151;
			4'd6:    res = 9'd181;
			4'd7:    res = 9'd212;
			4'd8:    res = 9'd243;
			4'd9:    res = 9'd273;
			4'd10:   res = 9'd304;
			4'd11:   res = 9'd334;
			default: res = 9'd0;
		endcase
		return res;
	endfunction

endpackage

[hdl/unix_to_dos_timestamp.sv]
// Throughput: one beat per cycle while m_axis_tready does not stall the output;
// nine register stages, each with its own valid bit, so a stall only holds
// stages that are occupied.
// Reset (arst_n low) clears all valid bits and sets the timezone offset to
// zero minutes west.
// ----------------------------------------------------------------------------
// unix_to_dos_timestamp
// Converts signed UNIX seconds to the packed FAT/DOS time and date words,
// after subtracting a timezone offset and clamping to 1 Jan 1980.
// ----------------------------------------------------------------------------
module unix_to_dos_timestamp (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [10:0] cfg_wr_data,   // minutes_west, signed
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] unix_seconds, signed
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // [15:0] dos_time, [31:16] dos_date
);
	import u2dts_pkg::*;

	// Epoch plus offset in seconds, precomputed at every configuration write.
	logic [28:0] base_q;
	logic [17:0] off_secs;
	logic [29:0] base_n;

	always_comb begin
		off_secs = ({{7{cfg_wr_data[10]}}, cfg_wr_data} << 6)
			- ({{7{cfg_wr_data[10]}}, cfg_wr_data} << 2);
		base_n = {1'b0, EPOCH_SECS} + {{12{off_secs[17]}}, off_secs};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= EPOCH_SECS;
		end else if (cfg_wr_en) begin
			base_q <= base_n[28:0];
		end
	end

	// Per-stage valid bits and advance signals.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic adv1, adv2, adv3, adv4, adv5, adv6, adv7, adv8, adv9;

	assign adv9 = !vld_s9 || m_axis_tready;
	assign adv8 = !vld_s8 || adv9;
	assign adv7 = !vld_s7 || adv8;
	assign adv6 = !vld_s6 || adv7;
	assign adv5 = !vld_s5 || adv6;
	assign adv4 = !vld_s4 || adv5;
	assign adv3 = !vld_s3 || adv4;
	assign adv2 = !vld_s2 || adv3;
	assign adv1 = !vld_s1 || adv2;

	assign s_axis_tready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= s_axis_tvalid;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
			if (adv4) vld_s4 <= vld_s3;
			if (adv5) vld_s5 <= vld_s4;
			if (adv6) vld_s6 <= vld_s5;
			if (adv7) vld_s7 <= vld_s6;
			if (adv8) vld_s8 <= vld_s7;
			if (adv9) vld_s9 <= vld_s8;
		end
	end

	// Stage 1: seconds since 1980 in local time, clamped at zero.
	logic [33:0] diff;
	logic [30:0] u_s1;

	assign diff = {{2{s_axis_tdata[31]}}, s_axis_tdata} - {5'd0, base_q};

	always_ff @(posedge clk) begin
		if (adv1) begin
			u_s1 <= diff[33] ? 31'd0 : diff[30:0];
		end
	end

	// Stage 2: estimate of (u >> 7) / 675, low by at most one.
	logic [47:0] dq_prod;
	logic [14:0] q0_s2;
	logic [23:0] v_s2;
	logic [6:0]  lo_s2;

	assign dq_prod = u_s1[30:7] * DAY_RECIP;

	always_ff @(posedge clk) begin
		if (adv2) begin
			q0_s2 <= dq_prod[47:33];
			v_s2  <= u_s1[30:7];
			lo_s2 <= u_s1[6:0];
		end
	end

	// Stage 3: remainder of the estimate, below twice the divisor.
	logic [24:0] qd_prod;
	logic [24:0] rem_full;
	logic [10:0] r_s3;
	logic [14:0] q0_s3;
	logic [6:0]  lo_s3;

	assign qd_prod  = q0_s2 * DAY_DIV;
	assign rem_full = {1'b0, v_s2} - qd_prod;

	always_ff @(posedge clk) begin
		if (adv3) begin
			r_s3  <= rem_full[10:0];
			q0_s3 <= q0_s2;
			lo_s3 <= lo_s2;
		end
	end

	// Stage 4: corrected day count and seconds of the day.
	logic        r_big;
	logic [10:0] r_fix;
	logic [14:0] day_s4;
	logic [16:0] sod_s4;

	assign r_big = r_s3 >= {1'b0, DAY_DIV};
	assign r_fix = r_big ? (r_s3 - {1'b0, DAY_DIV}) : r_s3;

	always_ff @(posedge clk) begin
		if (adv4) begin
			day_s4 <= r_big ? (q0_s3 + 15'd1) : q0_s3;
			sod_s4 <= {r_fix[9:0], lo_s3};
		end
	end

	// Stage 5: minutes of the day and a first year estimate.
	logic [30:0] mt_prod;
	logic [30:0] yr_prod;
	logic [10:0] mt_s5;
	logic [5:0]  yr0_s5;
	logic [16:0] sod_s5;
	logic [14:0] day_s5;

	assign mt_prod = sod_s4[16:2] * MIN_RECIP;
	assign yr_prod = day_s4 * YEAR_RECIP;

	always_ff @(posedge clk) begin
		if (adv5) begin
			mt_s5  <= mt_prod[29:19];
			yr0_s5 <= yr_prod[29:24];
			sod_s5 <= sod_s4;
			day_s5 <= day_s4;
		end
	end

	// Stage 6: seconds, hours, and the year after the leap-day correction.
	logic [18:0] hr_prod;
	logic [16:0] sec_full;
	logic [5:0]  yr1;
	logic [14:0] ybase0;
	logic [14:0] ybase1;
	logic        yr_high;
	logic [4:0]  hour_s6;
	logic [5:0]  sec_s6;
	logic [10:0] mt_s6;
	logic [5:0]  yr_s6;
	logic [14:0] ybase_s6;
	logic [14:0] day_s6;

	always_comb begin
		hr_prod  = mt_s5[10:2] * HOUR_RECIP;
		sec_full = sod_s5 - (17'(mt_s5) * 17'd60);
		yr1      = yr0_s5 - 6'd1;
		ybase0   = (15'(yr0_s5) * 15'(DAYS_YEAR)) + 15'((7'(yr0_s5) + 7'd3) >> 2);
		ybase1   = (15'(yr1) * 15'(DAYS_YEAR)) + 15'((7'(yr0_s5) + 7'd2) >> 2);
		yr_high  = ybase0 > day_s5;
	end

	always_ff @(posedge clk) begin
		if (adv6) begin
			hour_s6  <= hr_prod[17:13];
			sec_s6   <= sec_full[5:0];
			mt_s6    <= mt_s5;
			yr_s6    <= yr_high ? yr1 : yr0_s5;
			ybase_s6 <= yr_high ? ybase1 : ybase0;
			day_s6   <= day_s5;
		end
	end

	// Stage 7: minutes of the hour and day of the year.
	logic [10:0] min_full;
	logic [14:0] doy_full;
	logic [4:0]  hour_s7;
	logic [5:0]  min_s7;
	logic [5:0]  sec_s7;
	logic [5:0]  yr_s7;
	logic [8:0]  doy_s7;

	assign min_full = mt_s6 - (11'(hour_s6) * 11'd60);
	assign doy_full = day_s6 - ybase_s6;

	always_ff @(posedge clk) begin
		if (adv7) begin
			hour_s7 <= hour_s6;
			min_s7  <= min_full[5:0];
			sec_s7  <= sec_s6;
			yr_s7   <= yr_s6;
			doy_s7  <= doy_full[8:0];
		end
	end

	// Stage 8: fold a leap year onto the common-year table; Feb 29 is flagged.
	logic        leap;
	logic        feb29_s8;
	logic [8:0]  nl_s8;
	logic [5:0]  yr_s8;
	logic [15:0] time_s8;

	assign leap = yr_s7[1:0] == 2'd0;

	always_ff @(posedge clk) begin
		if (adv8) begin
			feb29_s8 <= leap && (doy_s7 == FEB29_DOY);
			nl_s8    <= (leap && (doy_s7 > FEB29_DOY)) ? (doy_s7 - 9'd1) : doy_s7;
			yr_s8    <= yr_s7;
			time_s8  <= {hour_s7, min_s7, sec_s7[5:1]};
		end
	end

	// Stage 9: month search and day of the month.
	logic [3:0]  mon;
	logic [8:0]  mday_full;
	logic [3:0]  mon_fin;
	logic [4:0]  mday_fin;
	logic [15:0] time_s9;
	logic [15:0] date_s9;

	always_comb begin
		mon = 4'd1;
		for (int i = 1; i < 12; i++) begin
			if (nl_s8 >= month_start(4'(i))) begin
				mon = 4'(i + 1);
			end
		end
		mday_full = nl_s8 - month_start(mon - 4'd1) + 9'd1;
		if (feb29_s8) begin
			mon_fin  = 4'd2;
			mday_fin = 5'd29;
		end else begin
			mon_fin  = mon;
			mday_fin = mday_full[4:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv9) begin
			time_s9 <= time_s8;
			date_s9 <= {1'b0, yr_s8, mon_fin, mday_fin};
		end
	end

	assign m_axis_tvalid = vld_s9;
	assign m_axis_tdata  = {date_s9, time_s9};

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for unix_to_dos_timestamp. Timestamps are streamed in
// under random idling and back-pressure, and every output beat is compared with
// a behavioral model of the FAT/DOS encoding under the current timezone offset.
// ----------------------------------------------------------------------------
module tb;

	localparam int          LATENCY      = 9;
	localparam int          LIMIT_CYCLES = 200000;
	localparam int          IDLE_PCT     = 11;
	localparam longint      EPOCH_1980   = 64'sd315532800;
	localparam int unsigned DAYS_TO_1980 = 3652;

	typedef struct {
		logic [31:0] secs;
		logic [15:0] dos_time;
		logic [15:0] dos_date;
	} stamp_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [10:0] cfg_wr_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;

	stamp_t      stamps_due[$];
	logic [10:0] west_shadow;
	bit          steady_flow;
	bit          hold_req;
	int          hold_cycles;
	int          mismatches;
	int          stamps_sent;
	int          stamps_checked;
	int          zones_used;
	int          cycle_count;

	int unsigned month_first_day [0:11] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
		304, 334};

	unix_to_dos_timestamp u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Encodes one UNIX time as the DOS time and date words seen from a zone
	// that lies the given number of minutes west of UTC.
	function automatic stamp_t dos_stamp_of(input logic [31:0] secs, input logic [10:0] west);
		longint          local_t;
		longint unsigned s;
		int unsigned     day, year, leap, month, mday, nl_day;
		stamp_t          r;
		local_t = longint'($signed(secs)) - longint'($signed(west)) * 64'sd60;
		if (local_t < EPOCH_1980) begin
			local_t = EPOCH_1980;
		end
		s = local_t;
		r.secs = secs;
		r.dos_time = {5'((s / 3600) % 24), 6'((s / 60) % 60), 5'((s % 60) / 2)};

		day = int'(s / 86400) - DAYS_TO_1980;
		year = day / 365;
		leap = (year + 3) / 4;
		if (leap + 365 * year > day) begin
			year = year - 1;
			leap = (year + 3) / 4;
		end
		day = day - (leap + 365 * year);

		if (day == 59 && year % 4 == 0) begin
			month = 2;
			mday = 29;
		end else begin
			// Past Feb 29 of a leap year, fold back onto the common-year table.
			nl_day = (year % 4 != 0 || day <= 59) ? day : day - 1;
			month = 1;
			while (month < 12 && month_first_day[month] <= nl_day) begin
				month++;
			end
			mday = nl_day - month_first_day[month - 1] + 1;
		end
		r.dos_date = {7'(year), 4'(month), 5'(mday)};
		return r;
	endfunction

	function automatic logic [31:0] rand_seconds();
		case ($urandom_range(3))
			0:       return $urandom;
			1:       return 32'(315532800 + int'($urandom_range(200000)) - 100000);
			default: return $urandom_range(32'h7FFF_FFFF, 32'd315400000);
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] secs,
		input logic [15:0] got, input logic [15:0] want);
		$display("[%0t] mismatch %s for unix %0d: got %h want %h",
			$realtime, what, $signed(secs), got, want);
		mismatches++;
	endtask

	// Input side: every accepted beat gets its prediction queued.
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			stamps_due.push_back(dos_stamp_of(s_axis_tdata, west_shadow));
			stamps_sent++;
		end
	end

	// Output side: every accepted beat is checked against the oldest prediction.
	always @(posedge clk) begin
		stamp_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (stamps_due.size() == 0) begin
				$display("[%0t] unexpected output beat %h", $realtime, m_axis_tdata);
				mismatches++;
			end else begin
				want = stamps_due.pop_front();
				stamps_checked++;
				if (m_axis_tdata[15:0] !== want.dos_time) begin
					report_mismatch("dos_time", want.secs, m_axis_tdata[15:0], want.dos_time);
				end
				if (m_axis_tdata[31:16] !== want.dos_date) begin
					report_mismatch("dos_date", want.secs, m_axis_tdata[31:16], want.dos_date);
				end
			end
		end
	end

	// Receiver: random back-pressure, or a long hold-off when asked for.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (hold_cycles) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				m_axis_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, stamps_due.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_stamp(input logic [31:0] secs);
		while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= secs;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Stops offering beats and waits until the pipeline has emptied.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (stamps_due.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic set_minutes_west(input logic [10:0] west);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= west;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		west_shadow = west;
		zones_used++;
	endtask

	task automatic test_epoch_and_calendar();
		logic [31:0] points [$];
		set_minutes_west(11'd0);
		points = '{32'h8000_0000, 32'hFFFF_FFFF, 32'd0, 32'd315532799, 32'd315532800,
			32'd315532801, 32'd320630400, 32'd347155199, 32'd951782400, 32'd951868800,
			32'd983404799, 32'h7FFF_FFFF};
		foreach (points[i]) begin
			send_stamp(points[i]);
		end
		drain();
	endtask

	task automatic test_offset_extremes();
		logic [10:0] zones [$];
		int          shift;
		zones = '{11'h400, 11'h3FF, 11'h7C8, 11'd720};
		foreach (zones[z]) begin
			set_minutes_west(zones[z]);
			shift = int'($signed(zones[z])) * 60;
			// Straddle the 1980 clamp as seen from this zone, then the top of range.
			send_stamp(32'(315532800 + shift - 1));
			send_stamp(32'(315532800 + shift));
			send_stamp(32'h7FFF_FFFF);
		end
		drain();
	endtask

	task automatic test_random_stream();
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0:       set_minutes_west(11'd0);
				1:       set_minutes_west(11'h7C8);
				2:       set_minutes_west(11'd720);
				3:       set_minutes_west(11'h400);
				4:       set_minutes_west(11'h3FF);
				default: set_minutes_west(11'($urandom_range(2047)));
			endcase
			// One phase runs with no idling on either side.
			steady_flow = (phase == 2);
			repeat (65) begin
				send_stamp(rand_seconds());
			end
			drain();
		end
		steady_flow = 1'b0;
	endtask

	task automatic test_output_hold_off();
		set_minutes_west(11'($urandom_range(2047)));
		hold_cycles = 80;
		hold_req    = 1'b1;
		repeat (40) begin
			send_stamp(rand_seconds());
		end
		drain();
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		west_shadow   = '0;
		steady_flow   = 1'b0;
		hold_req      = 1'b0;
		hold_cycles   = 0;
		mismatches    = 0;
		stamps_sent   = 0;
		stamps_checked = 0;
		zones_used    = 0;
		cycle_count   = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_epoch_and_calendar();
		test_offset_extremes();
		test_random_stream();
		test_output_hold_off();
		drain();

		if (stamps_due.size() != 0) begin
			$display("%0d expected results never arrived", stamps_due.size());
			mismatches++;
		end
		$display("Encoded %0d timestamps (%0d checked) over %0d timezone settings,",
			stamps_sent, stamps_checked, zones_used);
		$display("including the 1980 clamp, leap days, range limits and a long output stall.");
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

[unix_to_dos_timestamp.f]
hdl/u2dts_pkg.sv
hdl/unix_to_dos_timestamp.sv
bench/tb.sv
